### design/four_channel_crc16_frame_packer_macros.svh
// Assertion helpers shared by the frame packer RTL.
// Both forms sample at the rising clock edge and are muted while reset is high.
`ifndef FOUR_CHANNEL_CRC16_FRAME_PACKER_MACROS_SVH
`define FOUR_CHANNEL_CRC16_FRAME_PACKER_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define CRCFP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds at a clock edge outside reset.
`define CRCFP_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### design/crcfp_pkg.sv
// ----------------------------------------------------------------------------
// crcfp_pkg
// Shared types, constants and CRC-16/MODBUS helpers for the frame packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crcfp_pkg;

   localparam int FRAME_DATA_BYTES = 8;
   localparam int FRAME_BYTES      = 10;
   localparam int CRC_STAGES       = FRAME_DATA_BYTES;
   localparam int BYTE_INDEX_W     = $clog2(FRAME_BYTES);

   localparam logic [15:0] CRC_SEED = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [BYTE_INDEX_W-1:0] LAST_BYTE_INDEX = BYTE_INDEX_W'(FRAME_BYTES - 1);
   localparam logic [BYTE_INDEX_W-1:0] CRC_LOW_INDEX   = BYTE_INDEX_W'(FRAME_DATA_BYTES);

   typedef struct packed {
      logic signed [15:0] channel_a;
      logic signed [15:0] channel_b;
      logic signed [15:0] channel_c;
      logic signed [15:0] channel_d;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_type;

   // One sample set with the CRC folded so far.
   typedef struct packed {
      req_type     req;
      logic [15:0] crc;
   } stage_type;

   // Data byte of the frame at position idx (0..7), low byte of each channel first.
   function automatic logic [7:0] data_byte(input req_type req, input logic [2:0] idx);
      logic [7:0] result;
      unique case (idx)
         3'd0: result = req.channel_a[7:0];
         3'd1: result = req.channel_a[15:8];
         3'd2: result = req.channel_b[7:0];
         3'd3: result = req.channel_b[15:8];
         3'd4: result = req.channel_c[7:0];
         3'd5: result = req.channel_c[15:8];
         3'd6: result = req.channel_d[7:0];
         3'd7: result = req.channel_d[15:8];
      endcase
      return result;
   endfunction

   // Fold one byte into a reflected CRC-16 accumulator.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] acc;
      acc = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

### design/crcfp_crc_stage.sv
// ----------------------------------------------------------------------------
// crcfp_crc_stage
// One pipeline register stage: folds one frame byte into the running CRC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crcfp_crc_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  crcfp_pkg::stage_type  in_stage,
   input  logic [7:0]            fold_byte,
   output logic                  out_valid,
   input  logic                  out_ready,
   output crcfp_pkg::stage_type  out_stage
);

   logic                 valid_ff;
   logic                 valid_in;
   crcfp_pkg::stage_type stage_ff;
   crcfp_pkg::stage_type stage_in;
   logic                 load;

   // Take a new transfer when empty or when the held one moves on.
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_ready && in_valid;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      stage_in     = in_stage;
      stage_in.crc = crcfp_pkg::crc_byte(in_stage.crc, fold_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

### design/crcfp_serializer.sv
// ----------------------------------------------------------------------------
// crcfp_serializer
// Holds one finished frame and sends its ten bytes, one per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "four_channel_crc16_frame_packer_macros.svh"

module crcfp_serializer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  crcfp_pkg::stage_type  in_stage,
   output logic                  rsp_strobe,
   output crcfp_pkg::rsp_type    rsp_payload
);

   logic                                  active_ff;
   logic                                  active_in;
   logic [crcfp_pkg::BYTE_INDEX_W-1:0]    count_ff;
   logic [crcfp_pkg::BYTE_INDEX_W-1:0]    count_in;
   crcfp_pkg::stage_type                  frame_ff;
   logic                                  at_last;
   logic                                  load;

   assign at_last  = active_ff && (count_ff == crcfp_pkg::LAST_BYTE_INDEX);
   // Accept the next frame while the last byte of this one goes out.
   assign in_ready = !active_ff || at_last;
   assign load     = in_ready && in_valid;

   always_comb begin
      active_in = active_ff;
      count_in  = count_ff;
      priority if (load) begin
         active_in = 1'b1;
         count_in  = '0;
      end else if (at_last) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= in_stage;
      end
   end

   always_comb begin
      rsp_payload.last_byte = (count_ff == crcfp_pkg::LAST_BYTE_INDEX);
      if (count_ff == crcfp_pkg::LAST_BYTE_INDEX) begin
         rsp_payload.frame_byte = frame_ff.crc[15:8];
      end else if (count_ff == crcfp_pkg::CRC_LOW_INDEX) begin
         rsp_payload.frame_byte = frame_ff.crc[7:0];
      end else begin
         rsp_payload.frame_byte = crcfp_pkg::data_byte(frame_ff.req, count_ff[2:0]);
      end
   end

   assign rsp_strobe = active_ff;

   `CRCFP_NEVER(a_count_range, clock, reset, active_ff && (count_ff > crcfp_pkg::LAST_BYTE_INDEX), "byte count beyond frame end")
   `CRCFP_ASSERT(a_load_at_end, clock, reset, (in_valid && active_ff && !at_last) |=> (active_ff && $stable(frame_ff)), "frame replaced before its last byte")
   `CRCFP_ASSERT(a_after_last, clock, reset, at_last |=> (!active_ff || (count_ff == '0)), "frame did not end or restart after last byte")

endmodule

### design/four_channel_crc16_frame_packer.sv
// ----------------------------------------------------------------------------
// four_channel_crc16_frame_packer
// Packs four 16-bit samples into a 10-byte frame closed by CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_payload (channels a..d) and raise start; the transfer
//   is taken at the rising edge where start is high and busy is low.
//   Output: each frame comes out as ten bytes on rsp_payload, one per cycle,
//   each valid for exactly one cycle while rsp_strobe is high: channel a low
//   and high byte, then b, c, d, then CRC low and CRC high. last_byte marks
//   the CRC high byte. The receiver cannot hold bytes off.
//   Path: a sample set, once taken, passes through the eight CRC stage
//   registers, then into the serializer, which sends its bytes. Bytes of
//   back-to-back frames follow each other with no gap.
//   Throughput: set by the byte-wide result port, one byte per cycle.
//   Eight CRC stages (one byte each) buffer up to eight sample sets, so a
//   burst of start pulses is absorbed before busy rises; busy then drops
//   each time the serializer takes the next frame.
//   Reset: clears all valid bits and the serializer; no frame is in flight
//   afterward and busy is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_channel_crc16_frame_packer (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  crcfp_pkg::req_type  req_payload,
   output logic                rsp_strobe,
   output crcfp_pkg::rsp_type  rsp_payload
);

   localparam int Stages = crcfp_pkg::CRC_STAGES;

   // Pipeline links: link 0 is the input port, link Stages feeds the serializer.
   logic                 link_valid [Stages+1];
   logic                 link_ready [Stages+1];
   crcfp_pkg::stage_type link_stage [Stages+1];

   // Seed the CRC with the sample set as it enters.
   assign link_valid[0]     = start;
   assign link_stage[0].req = req_payload;
   assign link_stage[0].crc = crcfp_pkg::CRC_SEED;
   // Hold off new transfers while the first stage cannot move.
   assign busy              = !link_ready[0];

   // Fold one data byte per stage, in frame order.
   for (genvar k = 0; k < Stages; k++) begin : g_crc
      logic [7:0] fold_byte;

      assign fold_byte = crcfp_pkg::data_byte(link_stage[k].req, 3'(k));

      crcfp_crc_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .in_stage  (link_stage[k]),
         .fold_byte (fold_byte),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1]),
         .out_stage (link_stage[k+1])
      );
   end

   // Send the finished frame one byte per cycle.
   crcfp_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (link_valid[Stages]),
      .in_ready    (link_ready[Stages]),
      .in_stage    (link_stage[Stages]),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule
